### rtl/sync_length_checksum_frame_receiver_assert.svh
// Assertion macros for the sync/length/checksum frame receiver.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define SLCF_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("frame receiver check failed");

// Next-cycle implication.
`define SLCF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("frame receiver check failed");

`endif

### rtl/slcf_pkg.sv
// Shared types and constants for the sync/length/checksum frame receiver.
// No dependencies.
package slcf_pkg;

  localparam int FRAME_BUFFER_SIZE_DEF = 256;

  localparam logic [7:0] SYNC_FIRST    = 8'hAA;
  localparam logic [7:0] SYNC_SECOND   = 8'h55;
  localparam logic [7:0] TIMEOUT_RESET = 8'd8;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // register index decoded from the word address
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OK      = 3'd1,
    EV_CSUM    = 3'd2,
    EV_BADLEN  = 3'd3,
    EV_SYNC    = 3'd4,
    EV_TIMEOUT = 3'd5
  } frame_event_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]   out_byte;
    logic [7:0]   frame_position;
    logic         byte_stored;
    frame_event_t frame_event;
    logic [7:0]   frame_bytes;
  } result_t;

endpackage

### rtl/slcf_req_if.sv
// Input channel: one received byte or one timer tick per beat.
// Depends on nothing but the valid/ready handshake.
interface slcf_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink (input valid, req_type, rx_byte, output ready);
endinterface

### rtl/slcf_rsp_if.sv
// Result channel: echoed byte, frame position, stored flag, frame event and frame byte count.
// Depends on nothing but the valid/ready handshake.
interface slcf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] frame_position;
  logic       byte_stored;
  logic [2:0] frame_event;
  logic [7:0] frame_bytes;

  modport source (output valid, out_byte, frame_position, byte_stored, frame_event,
                  frame_bytes, input ready);
  modport sink (input valid, out_byte, frame_position, byte_stored, frame_event,
                frame_bytes, output ready);
endinterface

### rtl/slcf_cfg.sv
// APB-style register block holding the frame timeout.
// Uses slcf_pkg for the reset value and register index.
module slcf_cfg
  import slcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  timeout_ticks
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_ticks <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_TIMEOUT) ? {24'd0, timeout_ticks} : 32'd0;

endmodule

### rtl/slcf_parse.sv
// Frame parser: sync hunt, length, checksum and timeout state, plus result register.
// Uses slcf_pkg for phases, events and item/result types.
module slcf_parse
  import slcf_pkg::*;
#(
  parameter int FRAME_BUFFER_SIZE = FRAME_BUFFER_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      item,
  input  logic [7:0] timeout_ticks,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    result
);

  localparam int CNT_W = $clog2(FRAME_BUFFER_SIZE + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BUFFER_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BUFFER_SIZE);
  localparam logic [8:0]       LEN_LIMIT = 9'(FRAME_BUFFER_SIZE);

  phase_t           phase, phase_next;
  logic             len_hi;
  logic             len_hi_next;
  logic [7:0]       remaining;
  logic [7:0]       remaining_next;
  logic [7:0]       running_sum;
  logic [7:0]       running_sum_next;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] stored_count_next;
  logic [7:0]       ticks;
  logic [7:0]       ticks_next;
  result_t          res_next;

  logic             take;
  logic             is_tick;
  logic [7:0]       b;
  logic [7:0]       ticks_sat;
  logic             tick_over;
  logic             bad_len;
  logic             last_byte;
  logic [CNT_W-1:0] base_count;
  logic [CNT_W-1:0] inc_count;
  logic             fits;
  logic [8:0]       count_ext;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign is_tick  = (item.req_type == REQ_TICK);
  assign b        = item.rx_byte;

  assign ticks_sat = (ticks == 8'hFF) ? ticks : ticks + 8'd1;
  assign tick_over = ticks_sat > timeout_ticks;
  assign bad_len   = (b != 8'd0) || (remaining == 8'd0) || ({1'b0, remaining} >= LEN_LIMIT);
  assign last_byte = (remaining == 8'd1);

  // a new 0xAA restarts the byte count
  assign base_count = (phase == PH_HUNT) ? '0 : stored_count;
  assign fits       = base_count < CNT_FULL;
  assign inc_count  = fits ? base_count + CNT_W'(1) : base_count;
  assign count_ext  = 9'(inc_count);

  always_comb begin
    phase_next = phase;
    if (is_tick) begin
      if (phase != PH_HUNT && tick_over) begin
        phase_next = PH_HUNT;
      end
    end else begin
      unique case (phase)
        PH_HUNT:  if (b == SYNC_FIRST) phase_next = PH_SYNC2;
        PH_SYNC2: phase_next = (b == SYNC_SECOND) ? PH_LEN : PH_HUNT;
        PH_LEN:   if (len_hi) phase_next = bad_len ? PH_HUNT : PH_DATA;
        PH_DATA:  if (last_byte) phase_next = PH_HUNT;
        default:  phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    len_hi_next       = len_hi;
    remaining_next    = remaining;
    running_sum_next  = running_sum;
    stored_count_next = stored_count;
    ticks_next        = ticks;
    res_next          = '{out_byte: 8'd0, frame_position: 8'd0, byte_stored: 1'b0,
                          frame_event: EV_NONE, frame_bytes: 8'd0};
    if (is_tick) begin
      if (phase != PH_HUNT) begin
        ticks_next = ticks_sat;
        if (tick_over) begin
          res_next.frame_event = EV_TIMEOUT;
        end
      end
    end else begin
      res_next.out_byte = b;
      unique case (phase)
        PH_HUNT: begin
          if (b == SYNC_FIRST) begin
            ticks_next                = 8'd0;
            stored_count_next         = inc_count;
            res_next.frame_position   = 8'(base_count);
            res_next.byte_stored      = fits;
          end
        end
        PH_SYNC2: begin
          if (b == SYNC_SECOND) begin
            stored_count_next       = inc_count;
            res_next.frame_position = 8'((base_count > CNT_LAST) ? CNT_LAST : base_count);
            res_next.byte_stored    = fits;
            len_hi_next             = 1'b0;
          end else begin
            res_next.frame_event = EV_SYNC;
          end
        end
        PH_LEN: begin
          stored_count_next       = inc_count;
          res_next.frame_position = 8'((base_count > CNT_LAST) ? CNT_LAST : base_count);
          res_next.byte_stored    = fits;
          if (!len_hi) begin
            remaining_next = b;
            len_hi_next    = 1'b1;
          end else begin
            len_hi_next = 1'b0;
            if (bad_len) begin
              res_next.frame_event = EV_BADLEN;
            end else begin
              running_sum_next = 8'd0;
            end
          end
        end
        PH_DATA: begin
          stored_count_next       = inc_count;
          res_next.frame_position = 8'((base_count > CNT_LAST) ? CNT_LAST : base_count);
          res_next.byte_stored    = fits;
          remaining_next          = remaining - 8'd1;
          if (!last_byte) begin
            running_sum_next = running_sum + b;
          end else if (running_sum == b) begin
            res_next.frame_event = EV_OK;
            res_next.frame_bytes = (count_ext > 9'd255) ? 8'hFF : count_ext[7:0];
          end else begin
            res_next.frame_event = EV_CSUM;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      len_hi       <= 1'b0;
      remaining    <= 8'd0;
      running_sum  <= 8'd0;
      stored_count <= '0;
      ticks        <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        len_hi       <= len_hi_next;
        remaining    <= remaining_next;
        running_sum  <= running_sum_next;
        stored_count <= stored_count_next;
        ticks        <= ticks_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

endmodule

### rtl/sync_length_checksum_frame_receiver.sv
// Sync/length/checksum frame receiver. Each input beat is a received byte or a timer
// tick; the block hunts for 0xAA 0x55, reads a little-endian 16-bit length (payload plus
// checksum byte), sums payload bytes mod 256 and checks the closing byte. Every beat
// produces exactly one result beat. Each beat passes through the input register, then the
// parser stage that updates frame state and loads the result register; one beat per
// cycle is sustained while the result channel accepts beats. The timeout register sits
// at byte address 0 of the APB port and resets to 8 ticks.
module sync_length_checksum_frame_receiver
  import slcf_pkg::*;
#(
  parameter int FRAME_BUFFER_SIZE = FRAME_BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  slcf_req_if.sink    req,
  slcf_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       s0_valid;
  item_t      s0_item;
  logic       p_ready;
  logic [7:0] timeout_ticks;
  result_t    res;
  logic       accept;
  logic       s0_tick;
  logic       tick_res_ok;

  assign req.ready = !s0_valid || p_ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (accept) begin
      s0_valid <= 1'b1;
    end else if (p_ready) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_item <= '{req_type: req.req_type, rx_byte: req.rx_byte};
    end
  end

  slcf_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  slcf_parse #(
    .FRAME_BUFFER_SIZE (FRAME_BUFFER_SIZE)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s0_valid),
    .in_ready      (p_ready),
    .item          (s0_item),
    .timeout_ticks (timeout_ticks),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .result        (res)
  );

  assign rsp.out_byte       = res.out_byte;
  assign rsp.frame_position = res.frame_position;
  assign rsp.byte_stored    = res.byte_stored;
  assign rsp.frame_event    = res.frame_event;
  assign rsp.frame_bytes    = res.frame_bytes;

  assign s0_tick     = s0_valid && p_ready && (s0_item.req_type == REQ_TICK);
  assign tick_res_ok = (res.out_byte == 8'd0) && !res.byte_stored &&
                       (res.frame_event == EV_NONE || res.frame_event == EV_TIMEOUT);

`include "sync_length_checksum_frame_receiver_assert.svh"

  // a good frame always has sync, length and checksum bytes counted
  `SLCF_ASSERT_SAME(a_ok_has_bytes, rsp.valid && res.frame_event == EV_OK, res.frame_bytes != 8'd0)

  // position never leaves the buffer
  `SLCF_ASSERT_SAME(a_pos_in_buf, rsp.valid, 9'(res.frame_position) < 9'(FRAME_BUFFER_SIZE))

  // a tick yields an empty beat with either no event or a timeout
  `SLCF_ASSERT_NEXT(a_tick_result, s0_tick, rsp.valid && tick_res_ok)

endmodule
